[rtl/tecs_pkg.sv]
// tecs_pkg: shared types and constants for the timer event compare scheduler.
// Holds command codes, register indexes, the sequencer state type and request/result structs.
// No dependencies.
package tecs_pkg;

	localparam int EVENTS_DEF    = 8;
	localparam int TIME_BITS_DEF = 24;

	localparam int FIELD_W = 24;   // width of time fields on the ports
	localparam int MASK_W  = 8;    // width of fired_mask

	localparam logic [FIELD_W-1:0] SLEEP_THR_RST = 24'd2;

	// configuration register indexes
	localparam logic [1:0] REG_EW_ENABLE  = 2'd0;
	localparam logic [1:0] REG_EW_ADVANCE = 2'd1;
	localparam logic [1:0] REG_SLEEP_THR  = 2'd2;

	typedef enum logic [1:0] {
		CMD_AT    = 2'd0,
		CMD_DELAY = 2'd1,
		CMD_POLL  = 2'd2,
		CMD_SLEEP = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCHED,
		ST_SUPD,
		ST_SUPD2,
		ST_PSET,
		ST_WALK,
		ST_DRAIN,
		ST_COMMIT,
		ST_SFIN1,
		ST_SFIN2,
		ST_RESULT
	} state_t;

	typedef struct packed {
		cmd_t               command;
		logic [2:0]         event_index;
		logic [FIELD_W-1:0] due_time;
		logic               cancel;
		logic [FIELD_W-1:0] now;
	} in_req_t;

	typedef struct packed {
		logic [MASK_W-1:0]  fired_mask;
		logic               early_fired;
		logic               sleep_ok;
		logic               compare_valid;
		logic [FIELD_W-1:0] compare_time;
	} out_res_t;

endpackage

[rtl/timer_event_compare_scheduler_core.sv]
// timer_event_compare_scheduler_core: event deadline table with wraparound compare,
// early wakeup tracking, poll and prepare-sleep, run by a small slot-walking sequencer.
// Depends on tecs_pkg.
//
// One request is worked at a time; in_stall is high from the accept until the result is
// loaded into the output register, which then waits on out_stall while the next request
// is already taken. The walk reads the slot table through its single read port (one slot
// per cycle). A schedule passes ST_SCHED, with the early wakeup enabled ST_SUPD and
// ST_SUPD2 and a walk when a cancel of the slot behind the early wakeup forces a rescan; a
// schedule to a slot past EVENTS skips to ST_RESULT; poll passes ST_PSET and a walk,
// prepare-sleep a walk, ST_SFIN1 and ST_SFIN2. A result held up by out_stall on the output
// register keeps the block busy. Times compare by the sign bit of their TIME_BITS-wide
// difference, so "a at or after b" means b lies less than half the counter range behind a.
// The table and the early wakeup time clear to invalid at reset; there is no clearing pass.
module timer_event_compare_scheduler_core
	import tecs_pkg::*;
#(
	parameter int EVENTS    = EVENTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [FIELD_W-1:0] cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  in_req_t            in_req,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output out_res_t           out_res
);

	localparam int TW = TIME_BITS;
	localparam int SW = (EVENTS > 1) ? $clog2(EVENTS) : 1;
	localparam int CW = (TW > FIELD_W) ? TW : FIELD_W;

	function automatic logic [TW-1:0] to_tw(input logic [FIELD_W-1:0] v);
		logic [TW+FIELD_W-1:0] w;
		w = {{TW{1'b0}}, v};
		return w[TW-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic [TW-1:0] v);
		logic [TW+FIELD_W-1:0] w;
		w = {{FIELD_W{1'b0}}, v};
		return w[FIELD_W-1:0];
	endfunction

	function automatic logic [SW-1:0] to_slot(input logic [2:0] v);
		logic [SW+2:0] w;
		w = {{SW{1'b0}}, v};
		return w[SW-1:0];
	endfunction

	state_t state_q, state_d;

	// request
	cmd_t          cmd_q;
	logic          cancel_q;
	logic [TW-1:0] et_q, now_q;

	// configuration
	logic               ew_en_q;
	logic [TW-1:0]      adv_q;
	logic [FIELD_W-1:0] thr_q;

	// slot table and early wakeup
	logic          tab_v_q [EVENTS];
	logic [TW-1:0] tab_t_q [EVENTS];
	logic          early_v_q;
	logic [TW-1:0] early_t_q;

	// schedule working regs
	logic          old_v_q, match_q;
	logic [TW-1:0] old_t_q, new_t_q, e_q;

	// walk control
	logic [SW-1:0] cnt_q;
	logic          rec_en_q;
	logic [TW-1:0] from_q;

	// walk stage 1: slot read plus differences
	logic          a_act_s1, a_v_s1, a_due_s1;
	logic [TW-1:0] a_t_s1, a_e_s1, a_d_s1;

	// walk accumulators
	logic          best_v_q, any_q, due_q;
	logic [TW-1:0] best_t_q, rem_q, wake_q;

	// sleep finish
	logic          refuse_q;
	logic [TW-1:0] rem2_q, wake2_q;

	// result being built
	logic [MASK_W-1:0] fired_q;
	logic              efire_q, sok_q, cval_q;
	logic [TW-1:0]     ctime_q;

	logic     out_valid_q;
	out_res_t out_q;

	// ---------------------------------------------------------------- datapath taps
	logic          in_acc, idx_ok, last_slot, load_out;
	logic          rd_v, rd_due, ew_fire, pull_in, early_hit;
	logic [TW-1:0] rd_t, sum_t, rd_e, rd_d, rd_nd;
	logic [TW-1:0] best_diff, cand_diff, add_diff, now_e, wake_e, early_rem;
	logic [CW-1:0] rem2_w, thr_w;

	assign rd_v      = tab_v_q[cnt_q];
	assign rd_t      = tab_t_q[cnt_q];
	assign rd_e      = rd_t - adv_q;
	assign rd_d      = rd_t - now_q;
	assign rd_nd     = now_q - rd_t;
	assign rd_due    = ~rd_nd[TW-1];
	assign sum_t     = et_q + ((cmd_q == CMD_DELAY) ? now_q : '0);
	assign add_diff  = early_t_q - e_q;
	assign now_e     = now_q - early_t_q;
	assign wake_e    = wake_q - early_t_q;
	assign early_rem = early_t_q - now_q;
	assign ew_fire   = ew_en_q & early_v_q & ~now_e[TW-1];
	assign pull_in   = ew_en_q & early_v_q & ~wake_e[TW-1];
	assign cand_diff = a_e_s1 - from_q;
	assign best_diff = best_t_q - a_e_s1;
	assign early_hit = a_v_s1 & ~cand_diff[TW-1] & (~best_v_q | ~best_diff[TW-1]);
	assign rem2_w    = CW'(rem2_q);
	assign thr_w     = CW'(thr_q);
	assign idx_ok    = int'(in_req.event_index) < EVENTS;
	assign last_slot = cnt_q == SW'(EVENTS - 1);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_req.command)
						CMD_AT, CMD_DELAY: state_d = idx_ok ? ST_SCHED : ST_RESULT;
						CMD_POLL:          state_d = ST_PSET;
						default:           state_d = ST_WALK;
					endcase
				end
			end
			ST_SCHED:  state_d = ew_en_q ? ST_SUPD : ST_RESULT;
			ST_SUPD:   state_d = ST_SUPD2;
			ST_SUPD2: begin
				if (cancel_q && early_v_q && old_v_q && match_q)
					state_d = ST_WALK;
				else
					state_d = ST_RESULT;
			end
			ST_PSET:   state_d = ST_WALK;
			ST_WALK:   state_d = last_slot ? ST_DRAIN : ST_WALK;
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = (cmd_q == CMD_SLEEP) ? ST_SFIN1 : ST_RESULT;
			ST_SFIN1:  state_d = ST_SFIN2;
			ST_SFIN2:  state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- control outputs
	always_comb begin
		in_stall = 1'b1;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_RESULT: load_out = !out_valid_q || !out_stall;
			default: begin
				in_stall = 1'b1;
				load_out = 1'b0;
			end
		endcase
	end

	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ew_en_q     <= 1'b0;
			adv_q       <= '0;
			thr_q       <= SLEEP_THR_RST;
			early_v_q   <= 1'b0;
			out_valid_q <= 1'b0;
			a_act_s1    <= 1'b0;
			cnt_q       <= '0;
			rec_en_q    <= 1'b0;
			for (int i = 0; i < EVENTS; i++)
				tab_v_q[i] <= 1'b0;
		end else begin
			state_q  <= state_d;
			a_act_s1 <= state_q == ST_WALK;

			if (cfg_write) begin
				case (cfg_index)
					REG_EW_ENABLE:  ew_en_q <= cfg_data[0];
					REG_EW_ADVANCE: adv_q   <= to_tw(cfg_data);
					REG_SLEEP_THR:  thr_q   <= cfg_data;
					default: ;
				endcase
			end

			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					rec_en_q <= 1'b0;
					if (in_acc)
						cnt_q <= (in_req.command == CMD_AT || in_req.command == CMD_DELAY)
							? to_slot(in_req.event_index) : '0;
				end
				ST_SCHED: tab_v_q[cnt_q] <= ~cancel_q;
				ST_SUPD2: begin
					if (!cancel_q) begin
						if (!early_v_q || !add_diff[TW-1])
							early_v_q <= 1'b1;
					end else if (early_v_q && old_v_q && match_q) begin
						rec_en_q <= 1'b1;
						cnt_q    <= '0;
					end
				end
				ST_PSET: rec_en_q <= ew_fire;
				ST_WALK: begin
					if (cmd_q == CMD_POLL && rd_v && rd_due)
						tab_v_q[cnt_q] <= 1'b0;
					if (!last_slot)
						cnt_q <= cnt_q + SW'(1);
				end
				ST_COMMIT: begin
					if (rec_en_q)
						early_v_q <= best_v_q;
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= in_req.command;
			cancel_q <= in_req.cancel;
			et_q     <= to_tw(in_req.due_time);
			now_q    <= to_tw(in_req.now);
			fired_q  <= '0;
			efire_q  <= 1'b0;
			sok_q    <= 1'b0;
			cval_q   <= 1'b0;
			ctime_q  <= '0;
			best_v_q <= 1'b0;
			best_t_q <= '0;
			any_q    <= 1'b0;
			due_q    <= 1'b0;
			rem_q    <= '0;
			wake_q   <= to_tw(in_req.now);
		end

		case (state_q)
			ST_SCHED: begin
				tab_t_q[cnt_q] <= cancel_q ? '0 : sum_t;
				old_v_q        <= rd_v;
				old_t_q        <= rd_t;
				new_t_q        <= sum_t;
			end
			ST_SUPD: begin
				e_q     <= new_t_q - adv_q;
				match_q <= (early_t_q + adv_q) == old_t_q;
			end
			ST_SUPD2: begin
				if (!cancel_q && (!early_v_q || !add_diff[TW-1]))
					early_t_q <= e_q;
				from_q <= early_t_q;
			end
			ST_PSET: begin
				efire_q <= ew_fire;
				from_q  <= now_q + TW'(1);
			end
			ST_WALK: begin
				if (cmd_q == CMD_POLL && rd_v && rd_due) begin
					tab_t_q[cnt_q] <= '0;
					for (int k = 0; k < MASK_W; k++) begin
						if (int'(cnt_q) == k)
							fired_q[k] <= 1'b1;
					end
				end
			end
			ST_COMMIT: begin
				if (rec_en_q)
					early_t_q <= best_t_q;
			end
			ST_SFIN1: begin
				refuse_q <= pull_in & ~now_e[TW-1];
				rem2_q   <= pull_in ? early_rem : rem_q;
				wake2_q  <= pull_in ? early_t_q : wake_q;
			end
			ST_SFIN2: begin
				if (!due_q) begin
					if (!any_q) begin
						sok_q <= 1'b1;
					end else if (!refuse_q && rem2_w >= thr_w) begin
						sok_q   <= 1'b1;
						cval_q  <= 1'b1;
						ctime_q <= wake2_q;
					end
				end
			end
			default: ;
		endcase

		// walk stage 1: one slot per cycle
		a_v_s1   <= rd_v;
		a_t_s1   <= rd_t;
		a_e_s1   <= rd_e;
		a_d_s1   <= rd_d;
		a_due_s1 <= rd_due;

		// walk stage 2: early wakeup minimum and sleep wake search
		if (a_act_s1) begin
			if (rec_en_q && early_hit) begin
				best_v_q <= 1'b1;
				best_t_q <= a_e_s1;
			end
			if (cmd_q == CMD_SLEEP && a_v_s1) begin
				if (a_due_s1) begin
					due_q <= 1'b1;
				end else if (!any_q || a_d_s1 < rem_q) begin
					any_q  <= 1'b1;
					rem_q  <= a_d_s1;
					wake_q <= a_t_s1;
				end
			end
		end

		if (load_out) begin
			out_q.fired_mask    <= fired_q;
			out_q.early_fired   <= efire_q;
			out_q.sleep_ok      <= sok_q;
			out_q.compare_valid <= cval_q;
			out_q.compare_time  <= to_field(ctime_q);
		end
	end

endmodule

[rtl/tecs_checker.sv]
// tecs_checker: port-level checks on the timer event compare scheduler, bound to the core.
// Depends on tecs_pkg and timer_event_compare_scheduler_core.
module tecs_checker
	import tecs_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input out_res_t out_res
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_res))
		else $error("stalled result changed");

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in work");

	// a new result appears just as the block goes back to taking requests
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result loaded while still busy");

	// compare time only offered with sleep allowed
	a_cmp_needs_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.compare_valid |-> out_res.sleep_ok)
		else $error("compare_valid without sleep_ok");

	// poll fields and sleep fields never mix
	a_poll_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_res.fired_mask != '0 || out_res.early_fired)
			|-> !out_res.sleep_ok && !out_res.compare_valid)
		else $error("poll result carries sleep fields");

endmodule

bind timer_event_compare_scheduler_core tecs_checker u_tecs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_res   (out_res)
);
